// ----- hw/rtl/bfqd_pkg.sv -----
// bfqd_pkg: shared constants, types and saturation helpers for the body-frame drag block
// no dependencies
`default_nettype none

package bfqd_pkg;

   localparam int DataWidth     = 32;
   localparam int QuatWidth     = 16;
   localparam int MatWidth      = 22;  // rotation matrix entry, q.14 after floor
   localparam int RootWidth     = 64;
   localparam int RootStages    = 16;
   localparam int StepsPerStage = 2;
   localparam int RootBase      = 5;   // first square root stage
   localparam int NumStages     = RootBase + RootStages + 4;
   localparam int AddrWidth     = 4;

   localparam logic [DataWidth-1:0] DensityReset = 32'h0001_0000;

   typedef enum logic [1:0] {
      CSR_DRAG     = 2'd0,
      CSR_RADIUS   = 2'd1,
      CSR_DENSITY  = 2'd2,
      CSR_FRICTION = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic                 hit;
      logic [DataWidth-1:0] val;
   } sat_type;

   typedef struct packed {
      logic [RootWidth-1:0] n;
      logic [RootWidth-1:0] r;
   } root_state_type;

   function automatic sat_type sat_s32(input logic signed [65:0] x);
      sat_type res;
      if (x > 66'sd2147483647) begin
         res.hit = 1'b1;
         res.val = 32'h7fff_ffff;
      end else if (x < -66'sd2147483648) begin
         res.hit = 1'b1;
         res.val = 32'h8000_0000;
      end else begin
         res.hit = 1'b0;
         res.val = x[31:0];
      end
      return res;
   endfunction

   function automatic sat_type sat_u32(input logic [63:0] x);
      sat_type res;
      if (|x[63:32]) begin
         res.hit = 1'b1;
         res.val = 32'hffff_ffff;
      end else begin
         res.hit = 1'b0;
         res.val = x[31:0];
      end
      return res;
   endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/bfqd_if.sv -----
// bfqd_req_if / bfqd_rsp_if: valid/ready channels for body state words and drag words
// depends on bfqd_pkg
`default_nettype none

interface bfqd_req_if;
   logic                                valid;
   logic                                ready;
   logic signed [bfqd_pkg::QuatWidth-1:0] quat_w;
   logic signed [bfqd_pkg::QuatWidth-1:0] quat_x;
   logic signed [bfqd_pkg::QuatWidth-1:0] quat_y;
   logic signed [bfqd_pkg::QuatWidth-1:0] quat_z;
   logic signed [bfqd_pkg::DataWidth-1:0] world_vel_x;
   logic signed [bfqd_pkg::DataWidth-1:0] world_vel_y;
   logic signed [bfqd_pkg::DataWidth-1:0] world_vel_z;
   logic signed [bfqd_pkg::DataWidth-1:0] body_rate_x;
   logic signed [bfqd_pkg::DataWidth-1:0] body_rate_y;
   logic signed [bfqd_pkg::DataWidth-1:0] body_rate_z;

   modport source (output valid, quat_w, quat_x, quat_y, quat_z, world_vel_x, world_vel_y,
                   world_vel_z, body_rate_x, body_rate_y, body_rate_z, input ready);
   modport sink   (input valid, quat_w, quat_x, quat_y, quat_z, world_vel_x, world_vel_y,
                   world_vel_z, body_rate_x, body_rate_y, body_rate_z, output ready);
endinterface

interface bfqd_rsp_if;
   logic                                valid;
   logic                                ready;
   logic signed [bfqd_pkg::DataWidth-1:0] force_x;
   logic signed [bfqd_pkg::DataWidth-1:0] force_y;
   logic signed [bfqd_pkg::DataWidth-1:0] force_z;
   logic signed [bfqd_pkg::DataWidth-1:0] torque_x;
   logic signed [bfqd_pkg::DataWidth-1:0] torque_y;
   logic signed [bfqd_pkg::DataWidth-1:0] torque_z;
   logic                                saturated;

   modport source (output valid, force_x, force_y, force_z, torque_x, torque_y, torque_z,
                   saturated, input ready);
   modport sink   (input valid, force_x, force_y, force_z, torque_x, torque_y, torque_z,
                   saturated, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/body_frame_quadratic_drag.sv -----
// body_frame_quadratic_drag: rotates world velocity into the body frame and returns
// quadratic drag force and torque; depends on bfqd_pkg, bfqd_if and bfqd_root
//
// The block accepts one body state word per cycle while the output side is not stalled and
// returns one drag word for each, in order. The datapath is the 16-stage square root
// (two bit steps per stage), behind five front stages (matrix, matrix products, body
// velocity with clip, squares, sum of squares) and four back stages (scale products, scale
// clip, component products, final negate/floor/clip). Each stage holds a valid bit and
// only moves when the stage after it has room, so bubbles are squeezed out and a stall on
// the output neither drops nor repeats a word. The drag scale from the coefficient
// registers is computed in its own short register chain (k1p, k1, k2p, k2) and settles
// after a register write. Registers are written over the APB-style csr port (byte address
// 4*index); write them only while the block is idle, the block itself does not enforce it.
`default_nettype none

module body_frame_quadratic_drag (
   input  logic                              clock,
   input  logic                              reset,
   bfqd_req_if.sink                          req_ch,
   bfqd_rsp_if.source                        rsp_ch,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [bfqd_pkg::AddrWidth-1:0]    csr_paddr,
   input  logic [bfqd_pkg::DataWidth-1:0]    csr_pwdata,
   output logic [bfqd_pkg::DataWidth-1:0]    csr_prdata,
   output logic                              csr_pready
);
   import bfqd_pkg::*;

   // configuration registers
   logic [DataWidth-1:0] drag_ff, radius_ff, density_ff, friction_ff;
   csr_index_type        csr_idx;
   logic                 csr_wr;

   assign csr_idx    = csr_index_type'(csr_paddr[3:2]);
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         drag_ff     <= '0;
         radius_ff   <= '0;
         density_ff  <= DensityReset;
         friction_ff <= '0;
      end else if (csr_wr) begin
         unique case (csr_idx)
            CSR_DRAG:     drag_ff     <= csr_pwdata;
            CSR_RADIUS:   radius_ff   <= csr_pwdata;
            CSR_DENSITY:  density_ff  <= csr_pwdata;
            CSR_FRICTION: friction_ff <= csr_pwdata;
            default:      drag_ff     <= drag_ff;
         endcase
      end
   end

   always_comb begin
      unique case (csr_idx)
         CSR_DRAG:     csr_prdata = drag_ff;
         CSR_RADIUS:   csr_prdata = radius_ff;
         CSR_DENSITY:  csr_prdata = density_ff;
         CSR_FRICTION: csr_prdata = friction_ff;
         default:      csr_prdata = '0;
      endcase
   end

   // drag scale chain: k1 = cd*r >> 16, k2 = k1*rho >> 17 (carries the one half)
   logic [63:0] k1p_ff, k2p_ff;
   sat_type     k1_ff, k2_ff;

   always_ff @(posedge clock) begin
      k1p_ff <= 64'(drag_ff) * 64'(radius_ff);
      k1_ff  <= sat_u32(k1p_ff >> 16);
      k2p_ff <= 64'(k1_ff.val) * 64'(density_ff);
      k2_ff  <= sat_u32(k2p_ff >> 17);
   end

   // valid chain, a stage loads when it is empty or the next one moves
   logic [NumStages-1:0] vld_ff, vld_in, en;

   always_comb begin
      en[NumStages-1] = !vld_ff[NumStages-1] || rsp_ch.ready;
      for (int k = NumStages - 2; k >= 0; k--) begin
         en[k] = !vld_ff[k] || en[k+1];
      end
      for (int k = 0; k < NumStages; k++) begin
         if (k == 0) begin
            vld_in[k] = en[k] ? req_ch.valid : vld_ff[k];
         end else begin
            vld_in[k] = en[k] ? vld_ff[k-1] : vld_ff[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   assign req_ch.ready = en[0];

   // stage 0: transposed rotation matrix, q.28 floored to q.14
   logic signed [MatWidth-1:0]  mq_ff [3][3];
   logic signed [DataWidth-1:0] vw0_ff [3];
   logic signed [DataWidth-1:0] wb0_ff [3];
   logic signed [35:0]          m_in [3][3];

   always_comb begin
      logic signed [31:0] pxx, pyy, pzz, pxy, pxz, pyz, pwx, pwy, pwz;
      logic signed [35:0] one;
      one = 36'sd1 <<< 28;
      pxx = req_ch.quat_x * req_ch.quat_x;
      pyy = req_ch.quat_y * req_ch.quat_y;
      pzz = req_ch.quat_z * req_ch.quat_z;
      pxy = req_ch.quat_x * req_ch.quat_y;
      pxz = req_ch.quat_x * req_ch.quat_z;
      pyz = req_ch.quat_y * req_ch.quat_z;
      pwx = req_ch.quat_w * req_ch.quat_x;
      pwy = req_ch.quat_w * req_ch.quat_y;
      pwz = req_ch.quat_w * req_ch.quat_z;
      m_in[0][0] = one - ((36'(pyy) + 36'(pzz)) <<< 1);
      m_in[0][1] = (36'(pxy) + 36'(pwz)) <<< 1;
      m_in[0][2] = (36'(pxz) - 36'(pwy)) <<< 1;
      m_in[1][0] = (36'(pxy) - 36'(pwz)) <<< 1;
      m_in[1][1] = one - ((36'(pxx) + 36'(pzz)) <<< 1);
      m_in[1][2] = (36'(pyz) + 36'(pwx)) <<< 1;
      m_in[2][0] = (36'(pxz) + 36'(pwy)) <<< 1;
      m_in[2][1] = (36'(pyz) - 36'(pwx)) <<< 1;
      m_in[2][2] = one - ((36'(pxx) + 36'(pyy)) <<< 1);
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
               mq_ff[i][j] <= MatWidth'(m_in[i][j] >>> 14);
            end
         end
         vw0_ff[0] <= req_ch.world_vel_x;
         vw0_ff[1] <= req_ch.world_vel_y;
         vw0_ff[2] <= req_ch.world_vel_z;
         wb0_ff[0] <= req_ch.body_rate_x;
         wb0_ff[1] <= req_ch.body_rate_y;
         wb0_ff[2] <= req_ch.body_rate_z;
      end
   end

   // stage 1: matrix times velocity products
   logic signed [53:0]          pr_ff [3][3];
   logic signed [DataWidth-1:0] wb1_ff [3];

   always_ff @(posedge clock) begin
      if (en[1]) begin
         for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
               pr_ff[i][j] <= mq_ff[i][j] * vw0_ff[j];
            end
            wb1_ff[i] <= wb0_ff[i];
         end
      end
   end

   // stage 2: row sums, floor to q16.16, clip
   logic signed [DataWidth-1:0] vb2_ff [3];
   logic signed [DataWidth-1:0] wb2_ff [3];
   logic                        f2_ff;
   sat_type                     vb_sat [3];

   always_comb begin
      logic signed [55:0] acc;
      for (int i = 0; i < 3; i++) begin
         acc = 56'(pr_ff[i][0]) + 56'(pr_ff[i][1]) + 56'(pr_ff[i][2]);
         vb_sat[i] = sat_s32(66'(acc >>> 14));
      end
   end

   always_ff @(posedge clock) begin
      if (en[2]) begin
         for (int i = 0; i < 3; i++) begin
            vb2_ff[i] <= vb_sat[i].val;
            wb2_ff[i] <= wb1_ff[i];
         end
         f2_ff <= vb_sat[0].hit | vb_sat[1].hit | vb_sat[2].hit;
      end
   end

   // stage 3: squares of the magnitudes
   logic [63:0]                 sqv_ff [3];
   logic [63:0]                 sqw_ff [3];
   logic signed [DataWidth-1:0] vb3_ff [3];
   logic signed [DataWidth-1:0] wb3_ff [3];
   logic                        f3_ff;
   logic [DataWidth-1:0]        av [3];
   logic [DataWidth-1:0]        aw [3];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         av[i] = vb2_ff[i][DataWidth-1] ? DataWidth'(-33'(vb2_ff[i])) : vb2_ff[i];
         aw[i] = wb2_ff[i][DataWidth-1] ? DataWidth'(-33'(wb2_ff[i])) : wb2_ff[i];
      end
   end

   always_ff @(posedge clock) begin
      if (en[3]) begin
         for (int i = 0; i < 3; i++) begin
            sqv_ff[i] <= 64'(av[i]) * 64'(av[i]);
            sqw_ff[i] <= 64'(aw[i]) * 64'(aw[i]);
            vb3_ff[i] <= vb2_ff[i];
            wb3_ff[i] <= wb2_ff[i];
         end
         f3_ff <= f2_ff;
      end
   end

   // stage 4: sums of squares
   logic [RootWidth-1:0]        sumv_ff, sumw_ff;
   logic signed [DataWidth-1:0] vb4_ff [3];
   logic signed [DataWidth-1:0] wb4_ff [3];
   logic                        f4_ff;

   always_ff @(posedge clock) begin
      if (en[4]) begin
         sumv_ff <= sqv_ff[0] + sqv_ff[1] + sqv_ff[2];
         sumw_ff <= sqw_ff[0] + sqw_ff[1] + sqw_ff[2];
         for (int i = 0; i < 3; i++) begin
            vb4_ff[i] <= vb3_ff[i];
            wb4_ff[i] <= wb3_ff[i];
         end
         f4_ff <= f3_ff;
      end
   end

   // square root stages, vectors and flag ride alongside
   logic [DataWidth-1:0]        magv, magw;
   logic signed [DataWidth-1:0] vbr_ff [RootStages][3];
   logic signed [DataWidth-1:0] wbr_ff [RootStages][3];
   logic [RootStages-1:0]       fr_ff;

   bfqd_root u_root_v (
      .clock    (clock),
      .stage_en (en[RootBase +: RootStages]),
      .radicand (sumv_ff),
      .root     (magv)
   );

   bfqd_root u_root_w (
      .clock    (clock),
      .stage_en (en[RootBase +: RootStages]),
      .radicand (sumw_ff),
      .root     (magw)
   );

   always_ff @(posedge clock) begin
      for (int g = 0; g < RootStages; g++) begin
         if (en[RootBase + g]) begin
            for (int i = 0; i < 3; i++) begin
               vbr_ff[g][i] <= (g == 0) ? vb4_ff[i] : vbr_ff[(g == 0) ? 0 : g - 1][i];
               wbr_ff[g][i] <= (g == 0) ? wb4_ff[i] : wbr_ff[(g == 0) ? 0 : g - 1][i];
            end
            fr_ff[g] <= (g == 0) ? f4_ff : fr_ff[(g == 0) ? 0 : g - 1];
         end
      end
   end

   // scale products
   localparam int StgScale = RootBase + RootStages;
   logic [63:0]                 psv_ff, psw_ff;
   logic signed [DataWidth-1:0] vb5_ff [3];
   logic signed [DataWidth-1:0] wb5_ff [3];
   logic                        f5_ff;

   always_ff @(posedge clock) begin
      if (en[StgScale]) begin
         psv_ff <= 64'(k2_ff.val) * 64'(magv);
         psw_ff <= 64'(friction_ff) * 64'(magw);
         for (int i = 0; i < 3; i++) begin
            vb5_ff[i] <= vbr_ff[RootStages-1][i];
            wb5_ff[i] <= wbr_ff[RootStages-1][i];
         end
         f5_ff <= fr_ff[RootStages-1];
      end
   end

   // scale clip, coefficient chain flags join here
   sat_type                     sv_ff, sw_ff;
   logic signed [DataWidth-1:0] vb6_ff [3];
   logic signed [DataWidth-1:0] wb6_ff [3];
   logic                        f6_ff;
   sat_type                     sv_in, sw_in;

   assign sv_in = sat_u32(psv_ff >> 16);
   assign sw_in = sat_u32(psw_ff >> 16);

   always_ff @(posedge clock) begin
      if (en[StgScale + 1]) begin
         sv_ff <= sv_in;
         sw_ff <= sw_in;
         for (int i = 0; i < 3; i++) begin
            vb6_ff[i] <= vb5_ff[i];
            wb6_ff[i] <= wb5_ff[i];
         end
         f6_ff <= f5_ff | k1_ff.hit | k2_ff.hit | sv_in.hit | sw_in.hit;
      end
   end

   // component products s*v and s_w*w
   logic signed [63:0] tv_ff [3];
   logic signed [63:0] tw_ff [3];
   logic               f7_ff;

   always_ff @(posedge clock) begin
      if (en[StgScale + 2]) begin
         for (int i = 0; i < 3; i++) begin
            tv_ff[i] <= $signed({1'b0, sv_ff.val}) * vb6_ff[i];
            tw_ff[i] <= $signed({1'b0, sw_ff.val}) * wb6_ff[i];
         end
         f7_ff <= f6_ff;
      end
   end

   // output register: negate, floor to q16.16, clip
   sat_type             fo_in [3];
   sat_type             to_in [3];
   logic [DataWidth-1:0] fo_ff [3];
   logic [DataWidth-1:0] to_ff [3];
   logic                 sat_ff;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         fo_in[i] = sat_s32((-(66'(tv_ff[i]))) >>> 16);
         to_in[i] = sat_s32((-(66'(tw_ff[i]))) >>> 16);
      end
   end

   always_ff @(posedge clock) begin
      if (en[NumStages-1]) begin
         for (int i = 0; i < 3; i++) begin
            fo_ff[i] <= fo_in[i].val;
            to_ff[i] <= to_in[i].val;
         end
         sat_ff <= f7_ff | fo_in[0].hit | fo_in[1].hit | fo_in[2].hit
                         | to_in[0].hit | to_in[1].hit | to_in[2].hit;
      end
   end

   assign rsp_ch.valid     = vld_ff[NumStages-1];
   assign rsp_ch.force_x   = fo_ff[0];
   assign rsp_ch.force_y   = fo_ff[1];
   assign rsp_ch.force_z   = fo_ff[2];
   assign rsp_ch.torque_x  = to_ff[0];
   assign rsp_ch.torque_y  = to_ff[1];
   assign rsp_ch.torque_z  = to_ff[2];
   assign rsp_ch.saturated = sat_ff;

endmodule

`default_nettype wire

// ----- hw/rtl/bfqd_root.sv -----
// bfqd_root: pipelined 64-bit integer square root, two bit steps per stage
// depends on bfqd_pkg; stage enables come from the parent's valid chain
`default_nettype none

module bfqd_root (
   input  logic                                 clock,
   input  logic [bfqd_pkg::RootStages-1:0]      stage_en,
   input  logic [bfqd_pkg::RootWidth-1:0]       radicand,
   output logic [bfqd_pkg::RootWidth/2-1:0]     root
);
   import bfqd_pkg::*;

   root_state_type st_ff [RootStages];
   root_state_type st_in [RootStages];

   function automatic root_state_type root_step(input root_state_type s,
                                                input logic [RootWidth-1:0] bitv);
      root_state_type res;
      logic [RootWidth-1:0] t;
      t = s.r + bitv;
      if (s.n >= t) begin
         res.n = s.n - t;
         res.r = (s.r >> 1) + bitv;
      end else begin
         res.n = s.n;
         res.r = s.r >> 1;
      end
      return res;
   endfunction

   always_comb begin
      root_state_type cur;
      for (int g = 0; g < RootStages; g++) begin
         if (g == 0) begin
            cur.n = radicand;
            cur.r = '0;
         end else begin
            cur = st_ff[g-1];
         end
         for (int k = 0; k < StepsPerStage; k++) begin
            cur = root_step(cur, RootWidth'(1) << (RootWidth - 2 - 2 * (g * StepsPerStage + k)));
         end
         st_in[g] = cur;
      end
   end

   always_ff @(posedge clock) begin
      for (int g = 0; g < RootStages; g++) begin
         if (stage_en[g]) begin
            st_ff[g] <= st_in[g];
         end
      end
   end

   assign root = st_ff[RootStages-1].r[RootWidth/2-1:0];

endmodule

`default_nettype wire

// ----- sim/bfqd_scoreboard.sv -----
// bfqd_scoreboard: drag predictor and in-order check of drag words
// depends on bfqd_pkg
`default_nettype none

package bfqd_scoreboard_pkg;

   typedef struct {
      logic signed [15:0] qw, qx, qy, qz;
      logic signed [31:0] vx, vy, vz;
      logic signed [31:0] wx, wy, wz;
   } body_state_t;

   typedef struct {
      logic [31:0] f[3];
      logic [31:0] t[3];
      logic        sat;
   } drag_word_t;

   class drag_scoreboard;
      logic [31:0] drag_coef = 0;
      logic [31:0] radius    = 0;
      logic [31:0] density   = bfqd_pkg::DensityReset;
      logic [31:0] friction  = 0;
      drag_word_t  pending[$];
      int          errors;
      int          checked;

      // floor shift on wide signed values
      static function longint fshr(longint x, int n);
         return x >>> n;
      endfunction

      static function logic signed [127:0] clip_s(logic signed [127:0] x, ref bit hit);
         if (x > 128'sd2147483647) begin
            hit = 1;
            return 128'sd2147483647;
         end
         if (x < -128'sd2147483648) begin
            hit = 1;
            return -128'sd2147483648;
         end
         return x;
      endfunction

      static function logic [127:0] clip_u(logic [127:0] x, ref bit hit);
         if (x > 128'hffff_ffff) begin
            hit = 1;
            return 128'hffff_ffff;
         end
         return x;
      endfunction

      static function logic [63:0] isqrt(logic [63:0] n);
         logic [63:0] r, b;
         r = 0;
         b = 64'h1 << 62;
         for (int i = 0; i < 32; i++) begin
            if (n >= r + b) begin
               n = n - (r + b);
               r = (r >> 1) + b;
            end else begin
               r = r >> 1;
            end
            b = b >> 2;
         end
         return r;
      endfunction

      static function logic [63:0] norm3(longint a, longint b, longint c);
         logic [63:0] s;
         longint v[3];
         v = '{a, b, c};
         s = 0;
         foreach (v[i]) begin
            logic [63:0] m;
            m = v[i] < 0 ? -v[i] : v[i];
            s = s + m * m;
         end
         return isqrt(s);
      endfunction

      static function void scale_vec(logic [63:0] s, longint v[3], ref logic [31:0] o[3],
                                     ref bit hit);
         logic signed [127:0] p;
         foreach (v[i]) begin
            p = $signed({64'd0, s}) * $signed(128'(v[i]));
            p = -p;
            p = clip_s(p >>> 16, hit);
            o[i] = p[31:0];
         end
      endfunction

      function drag_word_t predict_drag(body_state_t b);
         drag_word_t  d;
         bit          hit;
         longint      qw, qx, qy, qz, m[3][3], vw[3], vb[3], wb[3];
         logic signed [127:0] acc;
         logic [127:0] k1, k2, s, sw;
         longint one;
         hit = 0;
         one = 64'sd1 << 28;
         qw = b.qw; qx = b.qx; qy = b.qy; qz = b.qz;
         vw = '{longint'(b.vx), longint'(b.vy), longint'(b.vz)};
         wb = '{longint'(b.wx), longint'(b.wy), longint'(b.wz)};
         m[0][0] = one - 2*(qy*qy + qz*qz);
         m[0][1] = 2*(qx*qy + qw*qz);
         m[0][2] = 2*(qx*qz - qw*qy);
         m[1][0] = 2*(qx*qy - qw*qz);
         m[1][1] = one - 2*(qx*qx + qz*qz);
         m[1][2] = 2*(qy*qz + qw*qx);
         m[2][0] = 2*(qx*qz + qw*qy);
         m[2][1] = 2*(qy*qz - qw*qx);
         m[2][2] = one - 2*(qx*qx + qy*qy);
         for (int i = 0; i < 3; i++) begin
            acc = 0;
            for (int j = 0; j < 3; j++)
               acc += 128'(fshr(m[i][j], 14)) * 128'(vw[j]);
            acc = clip_s(acc >>> 14, hit);
            vb[i] = longint'(acc);
         end
         k1 = clip_u((128'(drag_coef) * radius) >> 16, hit);
         k2 = clip_u((k1 * density) >> 17, hit);
         s  = clip_u((k2 * norm3(vb[0], vb[1], vb[2])) >> 16, hit);
         sw = clip_u((128'(friction) * norm3(wb[0], wb[1], wb[2])) >> 16, hit);
         scale_vec(s[63:0], vb, d.f, hit);
         scale_vec(sw[63:0], wb, d.t, hit);
         d.sat = hit;
         return d;
      endfunction

      function void note_state(body_state_t b);
         pending.push_back(predict_drag(b));
      endfunction

      function bit check_word(drag_word_t got, output string why);
         drag_word_t e;
         why = "";
         checked++;
         if (pending.size() == 0) begin
            why = "drag word with nothing pending";
            return 0;
         end
         e = pending.pop_front();
         for (int i = 0; i < 3; i++) begin
            if (got.f[i] !== e.f[i])
               why = {why, $sformatf(" force[%0d] %h/%h", i, got.f[i], e.f[i])};
            if (got.t[i] !== e.t[i])
               why = {why, $sformatf(" torque[%0d] %h/%h", i, got.t[i], e.t[i])};
         end
         if (got.sat !== e.sat)
            why = {why, $sformatf(" saturated %b/%b", got.sat, e.sat)};
         return why == "";
      endfunction
   endclass

endpackage

`default_nettype wire

// ----- sim/body_frame_quadratic_drag_test.sv -----
// body_frame_quadratic_drag_test: drives body states and csr writes into the drag block
// depends on bfqd_pkg, bfqd_if, bfqd_scoreboard and the block itself
`default_nettype none

module body_frame_quadratic_drag_test;
   import bfqd_pkg::*;
   import bfqd_scoreboard_pkg::*;

   localparam int Latency   = 25;
   localparam int CycleLimit = 400000;

   logic clock;
   logic reset;
   logic csr_psel, csr_penable, csr_pwrite;
   logic [AddrWidth-1:0] csr_paddr;
   logic [DataWidth-1:0] csr_pwdata, csr_prdata;
   logic csr_pready;

   bfqd_req_if req_ch ();
   bfqd_rsp_if rsp_ch ();

   body_frame_quadratic_drag DUT (
      .clock(clock), .reset(reset), .req_ch(req_ch.sink), .rsp_ch(rsp_ch.source),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   drag_scoreboard board = new();
   int  mismatches;
   int  cycles;
   int  accepted;
   bit  calm;        // last part of the run: no idling on either side
   bit  hold_rsp;    // long output stall for the backpressure phase
   bit  stim_done;
   int  directed_count;

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // runaway guard
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CycleLimit) begin
         $display("timeout after %0d cycles", cycles);
         $display("simulation failed");
         $finish;
      end
   end

   task automatic report_mismatch(string what);
      mismatches++;
      $display("mismatch at cycle %0d:%s", cycles, what);
   endtask

   // ---------------------------------------------------------------- csr writes
   task automatic csr_write(csr_index_type idx, logic [31:0] value);
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= AddrWidth'(int'(idx) * 4);
      csr_pwdata  <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      // access phase completes on the next rising edge, pready tied high
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      case (idx)
         CSR_DRAG:     board.drag_coef = value;
         CSR_RADIUS:   board.radius    = value;
         CSR_DENSITY:  board.density   = value;
         CSR_FRICTION: board.friction  = value;
      endcase
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   // wait for the pipe to drain before the coefficient writes
   task automatic wait_idle();
      while (board.pending.size() != 0) @(posedge clock);
      repeat (Latency) @(posedge clock);
   endtask

   task automatic load_coefs(logic [31:0] cd, logic [31:0] r, logic [31:0] rho,
                             logic [31:0] tau);
      wait_idle();
      csr_write(CSR_DRAG, cd);
      csr_write(CSR_RADIUS, r);
      csr_write(CSR_DENSITY, rho);
      csr_write(CSR_FRICTION, tau);
      repeat (4) @(negedge clock);
   endtask

   // ---------------------------------------------------------------- input side
   task automatic send_state(body_state_t b);
      // random idle burst before the word
      if (!calm && $urandom_range(0, 3) == 0) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(negedge clock);
      end
      req_ch.valid       <= 1'b1;
      req_ch.quat_w      <= b.qw;
      req_ch.quat_x      <= b.qx;
      req_ch.quat_y      <= b.qy;
      req_ch.quat_z      <= b.qz;
      req_ch.world_vel_x <= b.vx;
      req_ch.world_vel_y <= b.vy;
      req_ch.world_vel_z <= b.vz;
      req_ch.body_rate_x <= b.wx;
      req_ch.body_rate_y <= b.wy;
      req_ch.body_rate_z <= b.wz;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      board.note_state(b);
      accepted++;
      @(negedge clock);
   endtask

   task automatic stop_sending();
      req_ch.valid <= 1'b0;
   endtask

   function automatic logic signed [15:0] quat_part();
      // mostly in range, sometimes the extreme values
      case ($urandom_range(0, 9))
         0:       return 16'sd16384;
         1:       return -16'sd16384;
         2:       return 16'($urandom);
         default: return 16'($signed($urandom_range(0, 32768)) - 16384);
      endcase
   endfunction

   function automatic logic signed [31:0] speed();
      case ($urandom_range(0, 9))
         0:       return 32'h7fff_ffff;
         1:       return 32'h8000_0000;
         2, 3:    return 32'($urandom);
         4:       return 32'($signed($urandom_range(0, 32'h0020_0000)) - 32'sh0010_0000);
         default: return 32'($signed($urandom_range(0, 32'h0400_0000)) - 32'sh0200_0000);
      endcase
   endfunction

   function automatic body_state_t random_state();
      body_state_t b;
      b.qw = quat_part(); b.qx = quat_part(); b.qy = quat_part(); b.qz = quat_part();
      // unit-ish quaternion in one of three draws: one axis rotations
      if ($urandom_range(0, 2) == 0) begin
         b.qw = 16'sd11585; b.qx = 0; b.qy = 0; b.qz = 0;
         case ($urandom_range(0, 2))
            0: b.qx = $urandom_range(0, 1) ? 16'sd11585 : -16'sd11585;
            1: b.qy = $urandom_range(0, 1) ? 16'sd11585 : -16'sd11585;
            default: b.qz = $urandom_range(0, 1) ? 16'sd11585 : -16'sd11585;
         endcase
      end
      b.vx = speed(); b.vy = speed(); b.vz = speed();
      b.wx = speed(); b.wy = speed(); b.wz = speed();
      return b;
   endfunction

   function automatic body_state_t make_state(int qw, int qx, int qy, int qz,
                                              int v, int w);
      body_state_t b;
      b.qw = qw; b.qx = qx; b.qy = qy; b.qz = qz;
      b.vx = v; b.vy = -v; b.vz = v >>> 1;
      b.wx = w; b.wy = w >>> 2; b.wz = -w;
      return b;
   endfunction

   task automatic directed_states();
      body_state_t d[$];
      d.push_back(make_state(16384, 0, 0, 0, 0, 0));                 // all zero motion
      d.push_back(make_state(16384, 0, 0, 0, 32'h0001_0000, 32'h0001_0000));
      d.push_back(make_state(16384, 0, 0, 0, 32'h7fff_ffff, 32'h7fff_ffff));
      d.push_back(make_state(16384, 0, 0, 0, 32'h8000_0000, 32'h8000_0000));
      d.push_back(make_state(-16384, 0, 0, 0, 32'h0003_0000, -32'h0002_0000));
      d.push_back(make_state(0, 16384, 0, 0, 32'h0005_8000, 32'h0000_4000));
      d.push_back(make_state(0, 0, 16384, 0, -32'h0005_8000, 32'h0010_0000));
      d.push_back(make_state(0, 0, 0, 16384, 32'h0100_0000, -32'h0100_0000));
      d.push_back(make_state(0, 0, 0, -16384, 32'h0000_0001, -32'h0000_0001));
      d.push_back(make_state(11585, 11585, 0, 0, 32'h0040_0000, 32'h0002_0000));
      // non-unit quaternions, body velocity clips
      d.push_back(make_state(16384, 16384, 16384, 16384, 32'h4000_0000, 32'h0001_0000));
      d.push_back(make_state(-16384, -16384, -16384, -16384, 32'h7fff_ffff, 0));
      d.push_back(make_state(0, 0, 0, 0, 32'h2000_0000, 32'h2000_0000));
      d.push_back(make_state(16384, -16384, 16384, -16384, 32'h8000_0000, 32'h8000_0000));
      d.push_back(make_state(-1, -1, -1, -1, -1, -1));
      foreach (d[i]) send_state(d[i]);
      directed_count += d.size();
      stop_sending();
   endtask

   // ---------------------------------------------------------------- output side
   always @(posedge clock) begin
      drag_word_t got;
      string      why;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         got.f[0] = rsp_ch.force_x;  got.f[1] = rsp_ch.force_y;  got.f[2] = rsp_ch.force_z;
         got.t[0] = rsp_ch.torque_x; got.t[1] = rsp_ch.torque_y; got.t[2] = rsp_ch.torque_z;
         got.sat = rsp_ch.saturated;
         if (!board.check_word(got, why)) report_mismatch(why);
      end
   end

   // receiver ready pattern: random stall bursts, a long hold when asked, none when calm
   initial begin
      int n;
      rsp_ch.ready = 1'b0;
      @(negedge clock);
      forever begin
         if (hold_rsp) begin
            rsp_ch.ready <= 1'b0;
            n = 0;
            while (n < 200) begin
               @(negedge clock);
               n++;
            end
            hold_rsp = 0;
         end else if (!calm && $urandom_range(0, 4) == 0) begin
            rsp_ch.ready <= 1'b0;
            repeat ($urandom_range(1, 12)) @(negedge clock);
         end else begin
            rsp_ch.ready <= 1'b1;
            repeat ($urandom_range(1, 20)) @(negedge clock);
         end
      end
   end

   // ---------------------------------------------------------------- main sequence
   initial begin
      int waited;
      reset        = 1'b1;
      csr_psel     = 1'b0;
      csr_penable  = 1'b0;
      csr_pwrite   = 1'b0;
      csr_paddr    = '0;
      csr_pwdata   = '0;
      req_ch.valid = 1'b0;
      req_ch.quat_w = 0; req_ch.quat_x = 0; req_ch.quat_y = 0; req_ch.quat_z = 0;
      req_ch.world_vel_x = 0; req_ch.world_vel_y = 0; req_ch.world_vel_z = 0;
      req_ch.body_rate_x = 0; req_ch.body_rate_y = 0; req_ch.body_rate_z = 0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // reset values of the coefficients first: force and torque are zero
      directed_states();
      // moderate coefficients
      load_coefs(32'h0000_8000, 32'h0001_0000, 32'h0002_0000, 32'h0000_4000);
      directed_states();
      // top of the range: both drag scale steps of the coefficient chain clip
      load_coefs(32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
      directed_states();

      // random phases through several coefficient settings
      for (int ph = 0; ph < 6; ph++) begin
         case (ph)
            0: load_coefs(32'h0000_4000, 32'h0000_8000, 32'h0001_0000, 32'h0000_0100);
            1: load_coefs($urandom, $urandom, $urandom, $urandom);
            2: load_coefs(0, 32'hffff_ffff, 0, 32'hffff_ffff);
            3: load_coefs($urandom_range(0, 32'h0004_0000), $urandom_range(0, 32'h0004_0000),
                          $urandom_range(0, 32'h0004_0000), $urandom_range(0, 32'h0004_0000));
            4: load_coefs(32'h0000_0001, 32'h0000_0001, 32'h0000_0001, 32'h0000_0001);
            default: begin
               load_coefs(32'h0001_0000, 32'h0000_2000, 32'h0001_8000, 32'h0000_0800);
               calm = 1;
            end
         endcase
         if (ph == 2) hold_rsp = 1;   // outputs stall while inputs keep coming
         repeat (150) send_state(random_state());
         stop_sending();
      end
      stim_done = 1;

      waited = 0;
      while (board.pending.size() != 0 && waited < 20000) begin
         @(posedge clock);
         waited++;
      end
      repeat (Latency + 10) @(posedge clock);
      if (board.pending.size() != 0)
         report_mismatch($sformatf(" %0d drag words never arrived", board.pending.size()));

      $display("covered %0d body states (%0d directed) over nine coefficient settings,",
               accepted, directed_count);
      $display("with random stalls, one long output hold and a stall-free tail");
      if (mismatches == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

`default_nettype wire
